FILE: design/lmcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lmcr_pkg;

   localparam int MODULE_COUNT = 8;
   localparam int MOD_IDX_W    = $clog2(MODULE_COUNT);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam logic [5:0] INVERT_ABOVE = 6'd15;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_RENDER = 1'b1
   } opcode_type;

   // one classified word handed from front to back
   typedef struct packed {
      opcode_type  opcode;
      logic [3:0]  address;
      logic [7:0]  value;
      logic        digit_row;
      logic [3:0]  hour_tens;
      logic [3:0]  hour_units;
      logic [3:0]  minute_tens;
      logic [3:0]  minute_units;
      logic        colon_on;
   } cmd_type;

   // 10-digit 8x16 font, digit major
   localparam logic [7:0] FONT_ROM [10][16] = '{
      '{8'h00,8'h78,8'h84,8'h84,8'h84,8'h84,8'h84,8'h84,
        8'h84,8'h84,8'h84,8'h84,8'h84,8'h78,8'h00,8'h00},
      '{8'h00,8'h04,8'h14,8'h44,8'h04,8'h04,8'h04,8'h04,
        8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h00,8'h00},
      '{8'h00,8'h78,8'h04,8'h04,8'h04,8'h04,8'h04,8'h78,
        8'h80,8'h80,8'h80,8'h80,8'h80,8'h78,8'h00,8'h00},
      '{8'h00,8'hF8,8'h04,8'h04,8'h04,8'h04,8'h04,8'hFC,
        8'h04,8'h04,8'h04,8'h04,8'h04,8'hF8,8'h00,8'h00},
      '{8'h00,8'h84,8'h84,8'h84,8'h84,8'h84,8'h84,8'h7C,
        8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h00,8'h00},
      '{8'h00,8'h78,8'h80,8'h80,8'h80,8'h80,8'h80,8'h78,
        8'h04,8'h04,8'h04,8'h04,8'h04,8'h78,8'h00,8'h00},
      '{8'h00,8'h78,8'h80,8'h80,8'h80,8'h80,8'h80,8'hF8,
        8'h84,8'h84,8'h84,8'h84,8'h84,8'h78,8'h00,8'h00},
      '{8'h00,8'hF8,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,
        8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h00,8'h00},
      '{8'h00,8'h78,8'h84,8'h84,8'h84,8'h84,8'h84,8'h78,
        8'h84,8'h84,8'h84,8'h84,8'h84,8'h78,8'h00,8'h00},
      '{8'h00,8'h78,8'h84,8'h84,8'h84,8'h84,8'h84,8'h7C,
        8'h04,8'h04,8'h04,8'h04,8'h04,8'h78,8'h00,8'h00}
   };

   // digits above nine are blank
   function automatic logic [7:0] font_byte(input logic [3:0] digit, input logic [3:0] row);
      logic [7:0] b;
      b = 8'h00;
      if (digit <= 4'd9) begin
         b = FONT_ROM[digit][row];
      end
      return b;
   endfunction

   function automatic logic [7:0] mirror8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/lmcr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lmcr_front
   import lmcr_pkg::*;
(
   input  wire logic       start,
   input  wire logic       queue_full,
   input  wire logic       opcode,
   input  wire logic [3:0] register_address,
   input  wire logic [7:0] register_value,
   input  wire logic [3:0] hour_tens,
   input  wire logic [3:0] hour_units,
   input  wire logic [3:0] minute_tens,
   input  wire logic [3:0] minute_units,
   input  wire logic       colon_on,
   output logic            busy,
   output logic            push,
   output cmd_type         cmd
);

   logic digit_row;
   logic drop;

   // rows 1 to 8 are digit rows
   assign digit_row = (register_address >= 4'd1) && (register_address <= 4'd8);

   // a render outside the digit rows yields nothing and is dropped
   assign drop = (opcode_type'(opcode) == OP_RENDER) && !digit_row;

   assign busy = queue_full;
   assign push = start && !queue_full && !drop;

   // pack the classified word
   always_comb begin
      cmd.opcode       = opcode_type'(opcode);
      cmd.address      = register_address;
      cmd.value        = register_value;
      cmd.digit_row    = digit_row;
      cmd.hour_tens    = hour_tens;
      cmd.hour_units   = hour_units;
      cmd.minute_tens  = minute_tens;
      cmd.minute_units = minute_units;
      cmd.colon_on     = colon_on;
   end

endmodule

`default_nettype wire

FILE: design/lmcr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lmcr_queue
   import lmcr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output logic         full,
   output logic         not_empty,
   output cmd_type      head
);

   cmd_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: design/lmcr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lmcr_back
   import lmcr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cmd_valid,
   input  wire cmd_type     cmd,
   input  wire logic [5:0]  intensity_level,
   output logic             pop,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_module_index,
   output logic [7:0]       rsp_address_byte,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_last
);

   logic [MOD_IDX_W-1:0] mod_ff, mod_in;
   logic                 strobe_ff, strobe_in;
   logic [2:0]           index_ff;
   logic [7:0]           addr_ff;
   logic [7:0]           data_ff, data_in;
   logic                 last_ff, last_in;

   logic                 upper;
   logic [3:0]           digit;
   logic [3:0]           row;
   logic [7:0]           b_font, b_shift, b_colon, b_inv;

   assign upper = mod_ff[MOD_IDX_W-1];
   assign pop   = cmd_valid && (mod_ff == MOD_IDX_W'(MODULE_COUNT - 1));

   // digit shown on the current module
   always_comb begin
      unique case (mod_ff)
         3'd0, 3'd7: digit = cmd.hour_tens;
         3'd1, 3'd6: digit = cmd.hour_units;
         3'd2, 3'd5: digit = cmd.minute_tens;
         default:    digit = cmd.minute_units;
      endcase
   end

   // lower modules take font rows 8..15, upper ones rows 7..0
   assign row = upper ? (4'd8 - cmd.address) : (4'd7 + cmd.address);

   // render one pixel byte
   always_comb begin
      b_font  = font_byte(digit, row);
      b_shift = ((mod_ff >= 3'd2) && (mod_ff <= 3'd5)) ? (b_font >> 2) : b_font;
      b_colon = b_shift;
      if (cmd.colon_on && ((cmd.address == 4'd2) || (cmd.address == 4'd3))) begin
         if ((mod_ff == 3'd2) || (mod_ff == 3'd5)) begin
            b_colon = b_colon | 8'h80;
         end
         if ((mod_ff == 3'd1) || (mod_ff == 3'd6)) begin
            b_colon = b_colon | 8'h01;
         end
      end
      b_inv = (intensity_level > INVERT_ABOVE) ? ~b_colon : b_colon;
   end

   // pick data for the current word
   always_comb begin
      unique case (cmd.opcode)
         OP_WRITE:  data_in = (cmd.digit_row && upper) ? mirror8(cmd.value) : cmd.value;
         OP_RENDER: data_in = upper ? mirror8(b_inv) : b_inv;
         default:   data_in = cmd.value;
      endcase
      strobe_in = cmd_valid;
      last_in   = pop;
      mod_in    = cmd_valid ? mod_ff + 1'b1 : mod_ff;
   end

   // module counter and strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         mod_ff    <= mod_in;
         strobe_ff <= strobe_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (cmd_valid) begin
         index_ff <= 3'(mod_ff);
         addr_ff  <= {4'd0, cmd.address};
         data_ff  <= data_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_module_index = index_ff;
   assign rsp_address_byte = addr_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_last         = last_ff;

endmodule

`default_nettype wire

FILE: design/led_matrix_clock_row_renderer.sv
`timescale 1ns / 1ps
`default_nettype none

// Renders (address, data) byte pairs for a chain of eight 8x8 LED matrix
// drivers showing an HH:MM clock. A command is taken when start is high and
// busy is low; a register write or a render of rows 1 to 8 then yields eight
// words, module 0 first, one per clock on the rsp_ ports with rsp_strobe high
// for one cycle each and rsp_last on the eighth. The receiver cannot stall.
// A taken command waits in the queue and its words leave through the output
// word register; a render of a row outside 1 to 8 yields nothing.
// The output sequencer emits one word per cycle and sends a command's words
// in a row. A two-entry command queue holds the command being sent
// plus one more, so busy rises only once a second command waits behind the
// one in progress, and back to back commands keep the outputs busy every
// cycle. Write the intensity register through csr_ only while no command is
// in flight.
module led_matrix_clock_row_renderer
   import lmcr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_opcode,
   input  wire logic [3:0] req_register_address,
   input  wire logic [7:0] req_register_value,
   input  wire logic [3:0] req_hour_tens,
   input  wire logic [3:0] req_hour_units,
   input  wire logic [3:0] req_minute_tens,
   input  wire logic [3:0] req_minute_units,
   input  wire logic       req_colon_on,
   output logic            rsp_strobe,
   output logic [2:0]      rsp_module_index,
   output logic [7:0]      rsp_address_byte,
   output logic [7:0]      rsp_data_byte,
   output logic            rsp_last,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [5:0] csr_intensity_level
);

   logic       push;
   logic       pop;
   logic       queue_full;
   logic       queue_not_empty;
   cmd_type    push_cmd;
   cmd_type    head_cmd;
   logic [5:0] intensity_ff, intensity_in;

   // intensity register
   assign csr_ready    = 1'b1;
   assign intensity_in = (csr_valid && csr_ready) ? csr_intensity_level : intensity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         intensity_ff <= 6'd1;
      end else begin
         intensity_ff <= intensity_in;
      end
   end

   lmcr_front u_front (
      .start            (start),
      .queue_full       (queue_full),
      .opcode           (req_opcode),
      .register_address (req_register_address),
      .register_value   (req_register_value),
      .hour_tens        (req_hour_tens),
      .hour_units       (req_hour_units),
      .minute_tens      (req_minute_tens),
      .minute_units     (req_minute_units),
      .colon_on         (req_colon_on),
      .busy             (busy),
      .push             (push),
      .cmd              (push_cmd)
   );

   lmcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (head_cmd)
   );

   lmcr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (queue_not_empty),
      .cmd              (head_cmd),
      .intensity_level  (intensity_ff),
      .pop              (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_module_index (rsp_module_index),
      .rsp_address_byte (rsp_address_byte),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

FILE: test/led_matrix_clock_row_renderer_tb.sv
`timescale 1ns / 1ps

module led_matrix_clock_row_renderer_tb;
   import lmcr_pkg::*;

   // one clock command as the sender sees it
   typedef struct {
      opcode_type op;
      logic [3:0] addr;
      logic [7:0] val;
      logic [3:0] hour_t;
      logic [3:0] hour_u;
      logic [3:0] min_t;
      logic [3:0] min_u;
      logic       colon;
   } clock_cmd_type;

   // one (address, data) pair for a module of the chain
   typedef struct {
      logic [2:0] module_idx;
      logic [7:0] addr_byte;
      logic [7:0] data_byte;
      logic       last;
   } byte_pair_type;

   // glyph table, digit major, font rows 0 to 15
   localparam logic [7:0] GLYPHS [10][16] = '{
      '{8'h00,8'h78,8'h84,8'h84,8'h84,8'h84,8'h84,8'h84,
        8'h84,8'h84,8'h84,8'h84,8'h84,8'h78,8'h00,8'h00},
      '{8'h00,8'h04,8'h14,8'h44,8'h04,8'h04,8'h04,8'h04,
        8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h00,8'h00},
      '{8'h00,8'h78,8'h04,8'h04,8'h04,8'h04,8'h04,8'h78,
        8'h80,8'h80,8'h80,8'h80,8'h80,8'h78,8'h00,8'h00},
      '{8'h00,8'hF8,8'h04,8'h04,8'h04,8'h04,8'h04,8'hFC,
        8'h04,8'h04,8'h04,8'h04,8'h04,8'hF8,8'h00,8'h00},
      '{8'h00,8'h84,8'h84,8'h84,8'h84,8'h84,8'h84,8'h7C,
        8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h00,8'h00},
      '{8'h00,8'h78,8'h80,8'h80,8'h80,8'h80,8'h80,8'h78,
        8'h04,8'h04,8'h04,8'h04,8'h04,8'h78,8'h00,8'h00},
      '{8'h00,8'h78,8'h80,8'h80,8'h80,8'h80,8'h80,8'hF8,
        8'h84,8'h84,8'h84,8'h84,8'h84,8'h78,8'h00,8'h00},
      '{8'h00,8'hF8,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,
        8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h00,8'h00},
      '{8'h00,8'h78,8'h84,8'h84,8'h84,8'h84,8'h84,8'h78,
        8'h84,8'h84,8'h84,8'h84,8'h84,8'h78,8'h00,8'h00},
      '{8'h00,8'h78,8'h84,8'h84,8'h84,8'h84,8'h84,8'h7C,
        8'h04,8'h04,8'h04,8'h04,8'h04,8'h78,8'h00,8'h00}
   };

   localparam int SETTLE_CYCLES = 40;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic       req_opcode = 1'b0;
   logic [3:0] req_register_address = 4'd0;
   logic [7:0] req_register_value = 8'd0;
   logic [3:0] req_hour_tens = 4'd0;
   logic [3:0] req_hour_units = 4'd0;
   logic [3:0] req_minute_tens = 4'd0;
   logic [3:0] req_minute_units = 4'd0;
   logic       req_colon_on = 1'b0;
   logic       rsp_strobe;
   logic [2:0] rsp_module_index;
   logic [7:0] rsp_address_byte;
   logic [7:0] rsp_data_byte;
   logic       rsp_last;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [5:0] csr_intensity_level = 6'd0;

   clock_cmd_type cmd_backlog[$];
   byte_pair_type due_pairs[$];
   logic [5:0] intensity_copy = 6'd1;
   bit         idle_on = 1'b1;
   int         mismatch_count = 0;

   led_matrix_clock_row_renderer i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_register_address(req_register_address),
      .req_register_value  (req_register_value),
      .req_hour_tens       (req_hour_tens),
      .req_hour_units      (req_hour_units),
      .req_minute_tens     (req_minute_tens),
      .req_minute_units    (req_minute_units),
      .req_colon_on        (req_colon_on),
      .rsp_strobe          (rsp_strobe),
      .rsp_module_index    (rsp_module_index),
      .rsp_address_byte    (rsp_address_byte),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_intensity_level (csr_intensity_level)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] flip_bits(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

   // digits above nine show as blank
   function automatic logic [7:0] glyph_row(input logic [3:0] digit, input logic [3:0] row);
      logic [7:0] b;
      b = 8'h00;
      if (digit <= 4'd9) begin
         b = GLYPHS[digit][row];
      end
      return b;
   endfunction

   // eight pairs per write or valid row render, none for other rows
   task automatic compute_pairs(input clock_cmd_type c);
      logic [3:0] digit [8];
      logic [7:0] b;
      logic [3:0] frow;
      logic       upper;
      logic       digit_row;
      byte_pair_type p;
      digit_row = (c.addr >= 4'd1) && (c.addr <= 4'd8);
      if (c.op == OP_RENDER && !digit_row) return;
      digit = '{c.hour_t, c.hour_u, c.min_t, c.min_u, c.min_u, c.min_t, c.hour_u, c.hour_t};
      for (int m = 0; m < 8; m++) begin
         upper = (m > 3);
         if (c.op == OP_WRITE) begin
            p.data_byte = (digit_row && upper) ? flip_bits(c.val) : c.val;
         end else begin
            frow = upper ? (4'd8 - c.addr) : (4'd7 + c.addr);
            b = glyph_row(digit[m], frow);
            if (m >= 2 && m <= 5) b = b >> 2;
            if (c.colon && (c.addr == 4'd2 || c.addr == 4'd3)) begin
               if (m == 2 || m == 5) b[7] = 1'b1;
               if (m == 1 || m == 6) b[0] = 1'b1;
            end
            if (intensity_copy > 6'd15) b = ~b;
            p.data_byte = upper ? flip_bits(b) : b;
         end
         p.module_idx = m[2:0];
         p.addr_byte  = {4'd0, c.addr};
         p.last       = (m == 7);
         due_pairs.push_back(p);
      end
   endtask

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic clock_cmd_type mk_cmd(input opcode_type op, input logic [3:0] addr,
                                            input logic [7:0] val, input logic [3:0] ht,
                                            input logic [3:0] hu, input logic [3:0] mt,
                                            input logic [3:0] mu, input logic colon);
      clock_cmd_type c;
      c.op = op;
      c.addr = addr;
      c.val = val;
      c.hour_t = ht;
      c.hour_u = hu;
      c.min_t = mt;
      c.min_u = mu;
      c.colon = colon;
      return c;
   endfunction

   // mostly proper renders, the rest writes, blank digits and dead rows
   function automatic clock_cmd_type random_cmd();
      clock_cmd_type c;
      int kind;
      kind = $urandom_range(0, 99);
      c.op = OP_RENDER;
      c.val = 8'($urandom_range(0, 255));
      c.colon = 1'($urandom_range(0, 1));
      c.addr = 4'($urandom_range(1, 8));
      c.hour_t = 4'($urandom_range(0, 9));
      c.hour_u = 4'($urandom_range(0, 9));
      c.min_t = 4'($urandom_range(0, 9));
      c.min_u = 4'($urandom_range(0, 9));
      if (kind < 15) begin
         c.hour_t = 4'($urandom_range(0, 15));
         c.hour_u = 4'($urandom_range(0, 15));
         c.min_t = 4'($urandom_range(0, 15));
         c.min_u = 4'($urandom_range(0, 15));
      end else if (kind < 32) begin
         c.op = OP_WRITE;
         c.addr = 4'($urandom_range(0, 15));
      end else if (kind < 40) begin
         c.addr = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
      end
      return c;
   endfunction

   // sender: follows busy, idles in random bursts
   int            gap_left = 0;
   clock_cmd_type cur_cmd;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) compute_pairs(cur_cmd);
         if (start && busy) begin
            // hold the word until taken
         end else if (gap_left != 0) begin
            start <= 1'b0;
            gap_left--;
         end else if (cmd_backlog.size() != 0) begin
            cur_cmd = cmd_backlog.pop_front();
            start                <= 1'b1;
            req_opcode           <= cur_cmd.op;
            req_register_address <= cur_cmd.addr;
            req_register_value   <= cur_cmd.val;
            req_hour_tens        <= cur_cmd.hour_t;
            req_hour_units       <= cur_cmd.hour_u;
            req_minute_tens      <= cur_cmd.min_t;
            req_minute_units     <= cur_cmd.min_u;
            req_colon_on         <= cur_cmd.colon;
            if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 11);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // receiver: every strobed word against the oldest pending pair
   byte_pair_type got_pair;
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (due_pairs.size() == 0) begin
            flag_mismatch($sformatf("word with nothing pending: mod %0d addr %02h data %02h",
                                    rsp_module_index, rsp_address_byte, rsp_data_byte));
         end else begin
            got_pair = due_pairs.pop_front();
            if (rsp_module_index !== got_pair.module_idx ||
                rsp_address_byte !== got_pair.addr_byte ||
                rsp_data_byte !== got_pair.data_byte || rsp_last !== got_pair.last) begin
               flag_mismatch($sformatf(
                  "got mod %0d addr %02h data %02h last %0b, want %0d %02h %02h %0b",
                  rsp_module_index, rsp_address_byte, rsp_data_byte, rsp_last,
                  got_pair.module_idx, got_pair.addr_byte, got_pair.data_byte,
                  got_pair.last));
            end
         end
      end
   end

   // wait for all pairs, then let any dead-row command clear the block
   task automatic drain();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || start || due_pairs.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_intensity(input logic [5:0] v);
      @(posedge clock);
      csr_valid           <= 1'b1;
      csr_intensity_level <= v;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      intensity_copy = v;
   endtask

   task automatic run_batch(input int n);
      repeat (n) cmd_backlog.push_back(random_cmd());
      drain();
   endtask

   // sequence of phases
   logic [5:0] levels [7];
   initial begin
      levels = '{6'd0, 6'd32, 6'd15, 6'd16, 6'd31, 6'd0, 6'd32};
      levels[5] = 6'($urandom_range(0, 32));
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words at the reset intensity
      cmd_backlog.push_back(mk_cmd(OP_WRITE, 4'd0, 8'h00, 0, 0, 0, 0, 0));
      cmd_backlog.push_back(mk_cmd(OP_WRITE, 4'd1, 8'h01, 15, 15, 15, 15, 1));
      cmd_backlog.push_back(mk_cmd(OP_WRITE, 4'd8, 8'h80, 0, 0, 0, 0, 0));
      cmd_backlog.push_back(mk_cmd(OP_WRITE, 4'd9, 8'hFF, 0, 0, 0, 0, 0));
      cmd_backlog.push_back(mk_cmd(OP_WRITE, 4'd15, 8'hA5, 0, 0, 0, 0, 0));
      cmd_backlog.push_back(mk_cmd(OP_WRITE, 4'd4, 8'h3C, 0, 0, 0, 0, 0));
      cmd_backlog.push_back(mk_cmd(OP_RENDER, 4'd1, 8'h00, 0, 1, 2, 3, 0));
      cmd_backlog.push_back(mk_cmd(OP_RENDER, 4'd2, 8'h00, 4, 5, 6, 7, 1));
      cmd_backlog.push_back(mk_cmd(OP_RENDER, 4'd3, 8'h00, 8, 9, 0, 1, 1));
      cmd_backlog.push_back(mk_cmd(OP_RENDER, 4'd3, 8'h00, 8, 9, 0, 1, 0));
      cmd_backlog.push_back(mk_cmd(OP_RENDER, 4'd4, 8'h00, 9, 9, 9, 9, 1));
      cmd_backlog.push_back(mk_cmd(OP_RENDER, 4'd5, 8'h00, 1, 2, 3, 4, 0));
      cmd_backlog.push_back(mk_cmd(OP_RENDER, 4'd6, 8'h00, 5, 6, 7, 8, 0));
      cmd_backlog.push_back(mk_cmd(OP_RENDER, 4'd7, 8'h00, 2, 3, 5, 9, 1));
      cmd_backlog.push_back(mk_cmd(OP_RENDER, 4'd8, 8'h00, 0, 0, 0, 0, 0));
      cmd_backlog.push_back(mk_cmd(OP_RENDER, 4'd2, 8'h00, 10, 11, 12, 15, 1));
      cmd_backlog.push_back(mk_cmd(OP_RENDER, 4'd8, 8'h00, 15, 15, 15, 15, 0));
      cmd_backlog.push_back(mk_cmd(OP_RENDER, 4'd0, 8'h00, 1, 2, 3, 4, 1));
      cmd_backlog.push_back(mk_cmd(OP_RENDER, 4'd9, 8'h00, 1, 2, 3, 4, 1));
      cmd_backlog.push_back(mk_cmd(OP_RENDER, 4'd15, 8'hFF, 9, 9, 9, 9, 1));
      cmd_backlog.push_back(mk_cmd(OP_RENDER, 4'd1, 8'hFF, 9, 8, 7, 6, 1));
      drain();

      // random phases over several intensity settings, the last without idling
      for (int ph = 0; ph < 7; ph++) begin
         idle_on = (ph == 6) ? 1'b0 : ($urandom_range(0, 3) != 0);
         load_intensity(levels[ph]);
         if (ph == 2) begin
            // sender waits for every pair before going on
            run_batch(30);
            run_batch(37);
         end else begin
            run_batch(67);
         end
      end

      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
